### rtl/core/spqs_pkg.sv
// Shared types and constants for the sprite part quad setup block.
package spqs_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OBJECT_X     = 3'd0,
    REG_OBJECT_Y     = 3'd1,
    REG_FACING_LEFT  = 3'd2,
    REG_PALETTE_BASE = 3'd3,
    REG_DEPTH_BASE   = 3'd4
  } cfg_reg_e;

  // part_flags bit positions
  localparam int unsigned FLAG_VFLIP       = 0;
  localparam int unsigned FLAG_HMIRROR     = 1;
  localparam int unsigned FLAG_TRIM_RIGHT  = 2;
  localparam int unsigned FLAG_TRIM_BOTTOM = 3;
  localparam int unsigned FLAG_TRIM_LEFT   = 4;
  localparam int unsigned FLAG_TRIM_TOP    = 5;

  typedef struct packed {
    logic signed [15:0] object_x;
    logic signed [15:0] object_y;
    logic               facing_left;
    logic [15:0]        palette_base;
    logic [15:0]        depth_base;
  } cfg_t;

  typedef struct packed {
    logic [5:0]         part_flags;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic signed [15:0] part_width;
    logic signed [15:0] part_height;
    logic [15:0]        palette_offset;
    logic [7:0]         tex_left;
    logic [7:0]         tex_top;
    logic [7:0]         tex_right;
    logic [7:0]         tex_bottom;
  } part_t;

  // after trimming
  typedef struct packed {
    logic               vflip;
    logic               hmir;
    logic [15:0]        dx;
    logic [15:0]        dy;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [15:0]        poff;
    logic [7:0]         u0;
    logic [7:0]         u1;
    logic [7:0]         v0;
    logic [7:0]         v1;
  } trim_t;

  // after placement relative to the object
  typedef struct packed {
    logic               vflip;
    logic               xflip;
    logic               facing;
    logic [15:0]        x;
    logic [15:0]        y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic [15:0]        poff;
    logic [7:0]         u0;
    logic [7:0]         u1;
    logic [7:0]         v0;
    logic [7:0]         v1;
  } place_t;

  typedef struct packed {
    logic signed [15:0] quad_left;
    logic signed [15:0] quad_right;
    logic signed [15:0] quad_top;
    logic signed [15:0] quad_bottom;
    logic [7:0]         uv_u_first;
    logic [7:0]         uv_u_second;
    logic [7:0]         uv_v_first;
    logic [7:0]         uv_v_second;
    logic [15:0]        palette_out;
    logic [15:0]        priority_out;
  } quad_t;

endpackage

### rtl/core/spqs_part_if.sv
// Input channel carrying one sprite part.
interface spqs_part_if;
  logic               valid;
  logic               ready;
  logic [5:0]         part_flags;
  logic signed [15:0] offset_x;
  logic signed [15:0] offset_y;
  logic signed [15:0] part_width;
  logic signed [15:0] part_height;
  logic [15:0]        palette_offset;
  logic [7:0]         tex_left;
  logic [7:0]         tex_top;
  logic [7:0]         tex_right;
  logic [7:0]         tex_bottom;

  modport source (
    output valid, part_flags, offset_x, offset_y, part_width, part_height,
           palette_offset, tex_left, tex_top, tex_right, tex_bottom,
    input  ready
  );
  modport sink (
    input  valid, part_flags, offset_x, offset_y, part_width, part_height,
           palette_offset, tex_left, tex_top, tex_right, tex_bottom,
    output ready
  );
endinterface

### rtl/core/spqs_quad_if.sv
// Output channel carrying one screen quad.
interface spqs_quad_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quad_left;
  logic signed [15:0] quad_right;
  logic signed [15:0] quad_top;
  logic signed [15:0] quad_bottom;
  logic [7:0]         uv_u_first;
  logic [7:0]         uv_u_second;
  logic [7:0]         uv_v_first;
  logic [7:0]         uv_v_second;
  logic [15:0]        palette_out;
  logic [15:0]        priority_out;

  modport source (
    output valid, quad_left, quad_right, quad_top, quad_bottom, uv_u_first,
           uv_u_second, uv_v_first, uv_v_second, palette_out, priority_out,
    input  ready
  );
  modport sink (
    input  valid, quad_left, quad_right, quad_top, quad_bottom, uv_u_first,
           uv_u_second, uv_v_first, uv_v_second, palette_out, priority_out,
    output ready
  );
endinterface

### rtl/core/spqs_cfg_if.sv
// Register write channel.
interface spqs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [spqs_pkg::CFG_IDX_W-1:0]   index;
  logic [spqs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/spqs_trim.sv
// Stage 1: trims size, offset and texture edges by the part flags.
module spqs_trim (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  spqs_pkg::part_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output spqs_pkg::trim_t out_data
);

  spqs_pkg::trim_t trim_next;
  logic vflip, hmir, tr, tb, tl, tt;

  assign vflip = in_data.part_flags[spqs_pkg::FLAG_VFLIP];
  assign hmir  = in_data.part_flags[spqs_pkg::FLAG_HMIRROR];
  assign tr    = in_data.part_flags[spqs_pkg::FLAG_TRIM_RIGHT];
  assign tb    = in_data.part_flags[spqs_pkg::FLAG_TRIM_BOTTOM];
  assign tl    = in_data.part_flags[spqs_pkg::FLAG_TRIM_LEFT];
  assign tt    = in_data.part_flags[spqs_pkg::FLAG_TRIM_TOP];

  always_comb begin
    trim_next.vflip = vflip;
    trim_next.hmir  = hmir;
    trim_next.w     = in_data.part_width - 16'(tr) - 16'(tl);
    trim_next.h     = in_data.part_height - 16'(tb) - 16'(tt);
    // the position moves with whichever trim sits at the mirrored origin
    trim_next.dx    = in_data.offset_x + 16'(tr & hmir) + 16'(tl & ~hmir);
    trim_next.dy    = in_data.offset_y + 16'(tb & vflip) + 16'(tt & ~vflip);
    trim_next.poff  = in_data.palette_offset;
    trim_next.u0    = in_data.tex_left + 8'(tl);
    trim_next.u1    = in_data.tex_right - 8'(tr);
    trim_next.v0    = in_data.tex_top + 8'(tt);
    trim_next.v1    = in_data.tex_bottom - 8'(tb);
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= trim_next;
    end
  end

endmodule

### rtl/core/spqs_place.sv
// Stage 2: places the part relative to the object, mirrored when facing left.
module spqs_place (
  input  logic             clk,
  input  logic             rst,
  input  spqs_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  spqs_pkg::trim_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output spqs_pkg::place_t out_data
);

  spqs_pkg::place_t place_next;

  always_comb begin
    place_next.vflip  = in_data.vflip;
    place_next.xflip  = in_data.hmir | cfg.facing_left;
    place_next.facing = cfg.facing_left;
    place_next.x      = cfg.facing_left ? 16'(cfg.object_x) - in_data.dx
                                        : 16'(cfg.object_x) + in_data.dx;
    place_next.y      = 16'(cfg.object_y) + in_data.dy;
    place_next.w      = in_data.w;
    place_next.h      = in_data.h;
    place_next.poff   = in_data.poff;
    place_next.u0     = in_data.u0;
    place_next.u1     = in_data.u1;
    place_next.v0     = in_data.v0;
    place_next.v1     = in_data.v1;
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= place_next;
    end
  end

endmodule

### rtl/core/spqs_edge.sv
// Stage 3: quad edges, texture flips, palette and priority; output register.
module spqs_edge (
  input  logic             clk,
  input  logic             rst,
  input  spqs_pkg::cfg_t   cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  spqs_pkg::place_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output spqs_pkg::quad_t  out_data
);

  spqs_pkg::quad_t quad_next;

  always_comb begin
    if (in_data.facing) begin
      quad_next.quad_left  = in_data.x - in_data.w + 16'd1;
      quad_next.quad_right = in_data.x + 16'd1;
    end else begin
      quad_next.quad_left  = in_data.x;
      quad_next.quad_right = in_data.x + in_data.w;
    end
    quad_next.quad_top    = in_data.y;
    quad_next.quad_bottom = in_data.y + in_data.h;
    if (in_data.xflip) begin
      quad_next.uv_u_first  = in_data.u1 - 8'd1;
      quad_next.uv_u_second = in_data.u0 - 8'd1;
    end else begin
      quad_next.uv_u_first  = in_data.u0;
      quad_next.uv_u_second = in_data.u1;
    end
    if (in_data.vflip) begin
      quad_next.uv_v_first  = in_data.v1 - 8'd1;
      quad_next.uv_v_second = in_data.v0 - 8'd1;
    end else begin
      quad_next.uv_v_first  = in_data.v0;
      quad_next.uv_v_second = in_data.v1;
    end
    quad_next.palette_out  = cfg.palette_base + in_data.poff;
    quad_next.priority_out = cfg.depth_base + 16'd1;
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= quad_next;
    end
  end

endmodule

### rtl/core/sprite_part_quad_setup_core.sv
// Top level of the sprite part quad setup block.
//
//   channel   modport  role
//   part_in   sink     sprite parts in (valid/ready)
//   quad_out  source   screen quads out (valid/ready)
//   cfg       sink     register writes, always ready
//
// One part per cycle sustained while quad_out.ready stays high. An accepted part
// passes through the trim, place and edge register stages in that order before
// quad_out.valid rises for it.
// Each stage holds one transaction and takes a new one when empty or when
// its downstream side takes the current one, so bubbles close up on a stall.
// Synchronous reset clears the stage valid bits and the object registers to
// zero; stage data is not reset.
module sprite_part_quad_setup_core (
  input  logic           clk,
  input  logic           rst,
  spqs_part_if.sink      part_in,
  spqs_quad_if.source    quad_out,
  spqs_cfg_if.sink       cfg
);

  spqs_pkg::cfg_t   cfg_regs;
  spqs_pkg::part_t  part;
  spqs_pkg::trim_t  trim_data;
  spqs_pkg::place_t place_data;
  spqs_pkg::quad_t  quad;
  logic trim_valid, trim_ready, place_valid, place_ready;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        spqs_pkg::REG_OBJECT_X:     cfg_regs.object_x     <= cfg.data;
        spqs_pkg::REG_OBJECT_Y:     cfg_regs.object_y     <= cfg.data;
        spqs_pkg::REG_FACING_LEFT:  cfg_regs.facing_left  <= cfg.data[0];
        spqs_pkg::REG_PALETTE_BASE: cfg_regs.palette_base <= cfg.data;
        spqs_pkg::REG_DEPTH_BASE:   cfg_regs.depth_base   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    part.part_flags     = part_in.part_flags;
    part.offset_x       = part_in.offset_x;
    part.offset_y       = part_in.offset_y;
    part.part_width     = part_in.part_width;
    part.part_height    = part_in.part_height;
    part.palette_offset = part_in.palette_offset;
    part.tex_left       = part_in.tex_left;
    part.tex_top        = part_in.tex_top;
    part.tex_right      = part_in.tex_right;
    part.tex_bottom     = part_in.tex_bottom;
  end

  spqs_trim u_trim (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (part_in.valid),
    .in_ready  (part_in.ready),
    .in_data   (part),
    .out_valid (trim_valid),
    .out_ready (trim_ready),
    .out_data  (trim_data)
  );

  spqs_place u_place (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .in_valid  (trim_valid),
    .in_ready  (trim_ready),
    .in_data   (trim_data),
    .out_valid (place_valid),
    .out_ready (place_ready),
    .out_data  (place_data)
  );

  spqs_edge u_edge (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .in_valid  (place_valid),
    .in_ready  (place_ready),
    .in_data   (place_data),
    .out_valid (quad_out.valid),
    .out_ready (quad_out.ready),
    .out_data  (quad)
  );

  assign quad_out.quad_left    = quad.quad_left;
  assign quad_out.quad_right   = quad.quad_right;
  assign quad_out.quad_top     = quad.quad_top;
  assign quad_out.quad_bottom  = quad.quad_bottom;
  assign quad_out.uv_u_first   = quad.uv_u_first;
  assign quad_out.uv_u_second  = quad.uv_u_second;
  assign quad_out.uv_v_first   = quad.uv_v_first;
  assign quad_out.uv_v_second  = quad.uv_v_second;
  assign quad_out.palette_out  = quad.palette_out;
  assign quad_out.priority_out = quad.priority_out;

endmodule

### dv/spqs_quad_checker.sv
// Checker for the sprite part quad setup block: predicts each quad and compares.
`timescale 1ns / 1ps

module spqs_quad_checker (
  input  logic        clk,
  input  logic        rst,
  spqs_part_if        part_mon,
  spqs_quad_if        quad_mon,
  spqs_cfg_if         cfg_mon,
  output int unsigned n_pending,
  output int unsigned n_fail
);

  localparam int unsigned MAX_PRINTED = 40;

  spqs_pkg::cfg_t  obj_cfg;
  spqs_pkg::quad_t quads_due[$];
  spqs_pkg::quad_t want;
  spqs_pkg::quad_t got;
  spqs_pkg::part_t seen;
  int unsigned     fail_tally;

  initial begin
    fail_tally = 0;
    obj_cfg    = '0;
    n_pending  = 0;
    n_fail     = 0;
  end

  function automatic spqs_pkg::quad_t quad_from_part(spqs_pkg::part_t p,
                                                     spqs_pkg::cfg_t c);
    spqs_pkg::quad_t q;
    logic [15:0] dx, dy, w, h, x, y, ox, oy;
    logic [7:0]  u0, u1, v0, v1;
    logic        vflip, hmir;
    dx    = p.offset_x;
    dy    = p.offset_y;
    w     = p.part_width;
    h     = p.part_height;
    u0    = p.tex_left;
    v0    = p.tex_top;
    u1    = p.tex_right;
    v1    = p.tex_bottom;
    ox    = c.object_x;
    oy    = c.object_y;
    vflip = p.part_flags[spqs_pkg::FLAG_VFLIP];
    hmir  = p.part_flags[spqs_pkg::FLAG_HMIRROR];
    // each trim drops a pixel; the position only moves for the trim at the origin side:
    // left or top normally, right when mirrored, bottom when flipped
    if (p.part_flags[spqs_pkg::FLAG_TRIM_RIGHT]) begin
      w = w - 16'd1;
      if (hmir) dx = dx + 16'd1;
      u1 = u1 - 8'd1;
    end
    if (p.part_flags[spqs_pkg::FLAG_TRIM_BOTTOM]) begin
      h = h - 16'd1;
      if (vflip) dy = dy + 16'd1;
      v1 = v1 - 8'd1;
    end
    if (p.part_flags[spqs_pkg::FLAG_TRIM_LEFT]) begin
      w = w - 16'd1;
      if (!hmir) dx = dx + 16'd1;
      u0 = u0 + 8'd1;
    end
    if (p.part_flags[spqs_pkg::FLAG_TRIM_TOP]) begin
      h = h - 16'd1;
      if (!vflip) dy = dy + 16'd1;
      v0 = v0 + 8'd1;
    end
    y = oy + dy;
    if (c.facing_left) begin
      x            = ox - dx;
      q.quad_left  = x - w + 16'd1;
      q.quad_right = x + 16'd1;
    end else begin
      x            = ox + dx;
      q.quad_left  = x;
      q.quad_right = x + w;
    end
    q.quad_top    = y;
    q.quad_bottom = y + h;
    if (hmir || c.facing_left) begin
      q.uv_u_first  = u1 - 8'd1;
      q.uv_u_second = u0 - 8'd1;
    end else begin
      q.uv_u_first  = u0;
      q.uv_u_second = u1;
    end
    if (vflip) begin
      q.uv_v_first  = v1 - 8'd1;
      q.uv_v_second = v0 - 8'd1;
    end else begin
      q.uv_v_first  = v0;
      q.uv_v_second = v1;
    end
    q.palette_out  = c.palette_base + p.palette_offset;
    q.priority_out = c.depth_base + 16'd1;
    return q;
  endfunction

  task automatic report_mismatch(string msg);
    if (fail_tally < MAX_PRINTED) $display("[%0t] quad mismatch: %s", $realtime, msg);
    fail_tally++;
  endtask

  task automatic check_field(string name, logic [15:0] g, logic [15:0] w);
    if (g !== w) report_mismatch($sformatf("%s got %h want %h", name, g, w));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      quads_due.delete();
      obj_cfg = '0;
    end else begin
      if (quad_mon.valid && quad_mon.ready) begin
        got.quad_left    = quad_mon.quad_left;
        got.quad_right   = quad_mon.quad_right;
        got.quad_top     = quad_mon.quad_top;
        got.quad_bottom  = quad_mon.quad_bottom;
        got.uv_u_first   = quad_mon.uv_u_first;
        got.uv_u_second  = quad_mon.uv_u_second;
        got.uv_v_first   = quad_mon.uv_v_first;
        got.uv_v_second  = quad_mon.uv_v_second;
        got.palette_out  = quad_mon.palette_out;
        got.priority_out = quad_mon.priority_out;
        if (quads_due.size() == 0) begin
          report_mismatch("quad transaction with no part outstanding");
        end else begin
          want = quads_due.pop_front();
          check_field("quad_left", got.quad_left, want.quad_left);
          check_field("quad_right", got.quad_right, want.quad_right);
          check_field("quad_top", got.quad_top, want.quad_top);
          check_field("quad_bottom", got.quad_bottom, want.quad_bottom);
          check_field("uv_u_first", 16'(got.uv_u_first), 16'(want.uv_u_first));
          check_field("uv_u_second", 16'(got.uv_u_second), 16'(want.uv_u_second));
          check_field("uv_v_first", 16'(got.uv_v_first), 16'(want.uv_v_first));
          check_field("uv_v_second", 16'(got.uv_v_second), 16'(want.uv_v_second));
          check_field("palette_out", got.palette_out, want.palette_out);
          check_field("priority_out", got.priority_out, want.priority_out);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          spqs_pkg::REG_OBJECT_X:     obj_cfg.object_x     = cfg_mon.data;
          spqs_pkg::REG_OBJECT_Y:     obj_cfg.object_y     = cfg_mon.data;
          spqs_pkg::REG_FACING_LEFT:  obj_cfg.facing_left  = cfg_mon.data[0];
          spqs_pkg::REG_PALETTE_BASE: obj_cfg.palette_base = cfg_mon.data;
          spqs_pkg::REG_DEPTH_BASE:   obj_cfg.depth_base   = cfg_mon.data;
          default: ;  // unmapped index, write dropped
        endcase
      end
      if (part_mon.valid && part_mon.ready) begin
        seen.part_flags     = part_mon.part_flags;
        seen.offset_x       = part_mon.offset_x;
        seen.offset_y       = part_mon.offset_y;
        seen.part_width     = part_mon.part_width;
        seen.part_height    = part_mon.part_height;
        seen.palette_offset = part_mon.palette_offset;
        seen.tex_left       = part_mon.tex_left;
        seen.tex_top        = part_mon.tex_top;
        seen.tex_right      = part_mon.tex_right;
        seen.tex_bottom     = part_mon.tex_bottom;
        quads_due.push_back(quad_from_part(seen, obj_cfg));
      end
    end
    n_pending <= quads_due.size();
    n_fail    <= fail_tally;
  end

endmodule

### dv/tb_top.sv
// Testbench top: clock, reset, part and register stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned HOLDOFF_CYCLES = 200;
  localparam int unsigned N_PHASES       = 10;
  localparam int unsigned PHASE_ITEMS    = 175;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam logic [spqs_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;

  localparam logic [5:0] F_VFLIP   = 6'(1 << spqs_pkg::FLAG_VFLIP);
  localparam logic [5:0] F_HMIRROR = 6'(1 << spqs_pkg::FLAG_HMIRROR);
  localparam logic [5:0] F_TRIM_LR = 6'((1 << spqs_pkg::FLAG_TRIM_LEFT) |
                                        (1 << spqs_pkg::FLAG_TRIM_RIGHT));
  localparam logic [5:0] F_ALL     = 6'h3F;

  logic        clk;
  logic        rst;
  int unsigned n_pending;
  int unsigned n_fail;
  int unsigned cycle_count;
  logic        calm;
  int unsigned holdoff_req;

  spqs_part_if part_if ();
  spqs_quad_if quad_if ();
  spqs_cfg_if  cfg_if ();

  sprite_part_quad_setup_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .part_in  (part_if),
    .quad_out (quad_if),
    .cfg      (cfg_if)
  );

  spqs_quad_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .part_mon  (part_if),
    .quad_mon  (quad_if),
    .cfg_mon   (cfg_if),
    .n_pending (n_pending),
    .n_fail    (n_fail)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // biased toward the corners of the 16-bit range
  function automatic logic [15:0] rand16();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand8();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic spqs_pkg::part_t mk_part(logic [5:0] f, logic [15:0] ox,
                                              logic [15:0] oy, logic [15:0] w,
                                              logic [15:0] h, logic [15:0] poff,
                                              logic [7:0] tl, logic [7:0] tt,
                                              logic [7:0] tr, logic [7:0] tb);
    spqs_pkg::part_t p;
    p.part_flags     = f;
    p.offset_x       = ox;
    p.offset_y       = oy;
    p.part_width     = w;
    p.part_height    = h;
    p.palette_offset = poff;
    p.tex_left       = tl;
    p.tex_top        = tt;
    p.tex_right      = tr;
    p.tex_bottom     = tb;
    return p;
  endfunction

  function automatic spqs_pkg::cfg_t mk_cfg(logic [15:0] x, logic [15:0] y, logic f,
                                            logic [15:0] pal, logic [15:0] dep);
    spqs_pkg::cfg_t c;
    c.object_x     = x;
    c.object_y     = y;
    c.facing_left  = f;
    c.palette_base = pal;
    c.depth_base   = dep;
    return c;
  endfunction

  // valid stays high across back-to-back parts; lowered only for a gap or by wait_drained
  task automatic send_part(spqs_pkg::part_t p, int unsigned gap);
    part_if.valid          <= 1'b1;
    part_if.part_flags     <= p.part_flags;
    part_if.offset_x       <= p.offset_x;
    part_if.offset_y       <= p.offset_y;
    part_if.part_width     <= p.part_width;
    part_if.part_height    <= p.part_height;
    part_if.palette_offset <= p.palette_offset;
    part_if.tex_left       <= p.tex_left;
    part_if.tex_top        <= p.tex_top;
    part_if.tex_right      <= p.tex_right;
    part_if.tex_bottom     <= p.tex_bottom;
    @(posedge clk);
    while (!part_if.ready) @(posedge clk);
    if (gap > 0) begin
      part_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    part_if.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [spqs_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic write_obj_cfg(spqs_pkg::cfg_t c);
    if ($urandom_range(2) == 0)
      write_reg(REG_UNMAPPED_LO + 3'($urandom_range(2)), 16'($urandom));
    write_reg(spqs_pkg::REG_OBJECT_X, c.object_x);
    write_reg(spqs_pkg::REG_OBJECT_Y, c.object_y);
    // upper bits of the facing write are don't-care
    write_reg(spqs_pkg::REG_FACING_LEFT, {15'($urandom), c.facing_left});
    write_reg(spqs_pkg::REG_PALETTE_BASE, c.palette_base);
    write_reg(spqs_pkg::REG_DEPTH_BASE, c.depth_base);
    cfg_if.valid <= 1'b0;
  endtask

  // output side: random stalls, plus a long hold-off on request
  initial begin : sink_side
    int unsigned stall_left;
    int unsigned holdoff_seen;
    stall_left   = 0;
    holdoff_seen = 0;
    quad_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        stall_left   = HOLDOFF_CYCLES;
      end else if (stall_left == 0 && !calm) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        quad_if.ready <= 1'b0;
        stall_left--;
      end else begin
        quad_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned    k;
    int unsigned    ph;
    int unsigned    n;
    int unsigned    gap;
    spqs_pkg::cfg_t c;
    rst                    <= 1'b1;
    calm                   <= 1'b0;
    holdoff_req            <= 0;
    part_if.valid          <= 1'b0;
    part_if.part_flags     <= '0;
    part_if.offset_x       <= '0;
    part_if.offset_y       <= '0;
    part_if.part_width     <= '0;
    part_if.part_height    <= '0;
    part_if.palette_offset <= '0;
    part_if.tex_left       <= '0;
    part_if.tex_top        <= '0;
    part_if.tex_right      <= '0;
    part_if.tex_bottom     <= '0;
    cfg_if.valid           <= 1'b0;
    cfg_if.index           <= spqs_pkg::REG_OBJECT_X;
    cfg_if.data            <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset register values
    send_part(mk_part('0, '0, '0, '0, '0, '0, '0, '0, '0, '0), pick_gap());
    for (k = 0; k < 6; k++)
      send_part(mk_part(6'(1 << k), 16'd100, -16'sd50, 16'd16, 16'd24, 16'h0010,
                        8'h10, 8'h20, 8'h30, 8'h40), pick_gap());
    // all trims on zero sizes and zero texture edges: everything wraps
    send_part(mk_part(F_ALL, '0, '0, '0, '0, '0, '0, '0, '0, '0), pick_gap());
    send_part(mk_part(F_ALL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF), pick_gap());
    send_part(mk_part('0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF), pick_gap());
    send_part(mk_part(F_VFLIP | F_HMIRROR, 16'h0005, 16'hFFFB, 16'h0020, 16'h0010,
                      16'h1234, 8'h00, 8'h80, 8'hFF, 8'h01), pick_gap());

    // facing left, extreme positions, palette and priority wrap
    wait_drained();
    write_obj_cfg(mk_cfg(16'h7FFF, 16'h8000, 1'b1, 16'hFFFF, 16'hFFFF));
    send_part(mk_part('0, 16'h0010, 16'h0010, 16'h0008, 16'h0008, 16'h0001,
                      8'h04, 8'h08, 8'h0C, 8'h10), pick_gap());
    // facing left together with the part mirror
    send_part(mk_part(F_HMIRROR, 16'h0010, 16'h0010, 16'h0008, 16'h0008, 16'h0001,
                      8'h04, 8'h08, 8'h0C, 8'h10), pick_gap());
    send_part(mk_part(F_ALL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF,
                      8'hFF, 8'hFF, 8'hFF, 8'hFF), pick_gap());
    send_part(mk_part(F_ALL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, '0,
                      '0, '0, '0, '0), pick_gap());
    send_part(mk_part('0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000,
                      '0, 8'hFF, '0, 8'hFF), pick_gap());

    wait_drained();
    write_obj_cfg(mk_cfg(16'h8000, 16'h7FFF, 1'b0, 16'h0001, 16'h7FFF));
    send_part(mk_part(F_ALL, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                      8'h00, 8'hFF, 8'h80, 8'h7F), pick_gap());
    send_part(mk_part(F_HMIRROR, 16'hFFFF, 16'h0001, 16'h0040, 16'h0040, 16'h00FF,
                      8'h10, 8'h10, 8'h50, 8'h50), pick_gap());
    send_part(mk_part(F_TRIM_LR | F_HMIRROR, 16'h0003, 16'h0003, 16'h0002, 16'h0002,
                      16'h0002, 8'h01, 8'h01, 8'h02, 8'h02), pick_gap());

    // random phases, each under its own register setting
    for (ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      if (ph == 0)
        c = mk_cfg(16'h7FFF, 16'h7FFF, 1'b1, 16'hFFFF, 16'hFFFF);
      else if (ph == N_PHASES - 1)
        c = mk_cfg(16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000);
      else
        c = mk_cfg(rand16(), rand16(), 1'($urandom_range(1)), rand16(), rand16());
      write_obj_cfg(c);
      calm <= (ph != 2) && ($urandom_range(3) == 0);
      // output held off while parts keep coming: pipeline fills and stalls
      if (ph == 2) holdoff_req <= holdoff_req + 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && (ph == 0 || $urandom_range(1) == 1))
          wait_drained();
        gap = (calm || (ph == 2 && n < 40)) ? 0 : pick_gap();
        send_part(mk_part(6'($urandom_range(63)), rand16(), rand16(), rand16(), rand16(),
                          rand16(), rand8(), rand8(), rand8(), rand8()), gap);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/spqs_pkg.sv
rtl/core/spqs_part_if.sv
rtl/core/spqs_quad_if.sv
rtl/core/spqs_cfg_if.sv
rtl/core/spqs_trim.sv
rtl/core/spqs_place.sv
rtl/core/spqs_edge.sv
rtl/core/sprite_part_quad_setup_core.sv
dv/spqs_quad_checker.sv
dv/tb_top.sv
